// File: rtl/huffman_two_level_table_builder_assert.svh
// Assertion macros shared by the table builder RTL.
`ifndef HUFFMAN_TWO_LEVEL_TABLE_BUILDER_ASSERT_SVH
`define HUFFMAN_TWO_LEVEL_TABLE_BUILDER_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while reset is asserted.
`define HTLB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table builder check failed");

// Next-cycle implication, sampled on clk and off while reset is asserted.
`define HTLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table builder check failed");

`endif

// File: rtl/htlb_pkg.sv
// Package with the constants, item types and command codes of the table builder.
`default_nettype none

package htlb_pkg;

    localparam int ROOT_BITS       = 8;
    localparam int MAX_CODE_LENGTH = 16;
    localparam int TABLE_DEPTH     = 1024;
    localparam int SYMBOL_DEPTH    = 256;

    localparam int LEN_W   = 5;
    localparam int CNT_W   = 9;
    localparam int SYM_W   = 8;
    localparam int VAL_W   = 10;
    localparam int RADDR_W = 10;
    localparam int TBL_W   = LEN_W + VAL_W;
    localparam int TAB_AW  = $clog2(TABLE_DEPTH);
    localparam int SYM_AW  = $clog2(SYMBOL_DEPTH);

    localparam int SUB_MAX = MAX_CODE_LENGTH - ROOT_BITS;
    localparam int TB_W    = $clog2(SUB_MAX + 1);
    localparam int SIZE_W  = SUB_MAX + 1;
    localparam int LOW_W   = SIZE_W + 1;
    localparam int REPS_W  = ((ROOT_BITS > SUB_MAX) ? ROOT_BITS : SUB_MAX) + 1;
    localparam int LEFT_W  = ((SIZE_W > CNT_W) ? SIZE_W : CNT_W) + 2;
    localparam int IDX_W   = $clog2(MAX_CODE_LENGTH * ((1 << CNT_W) - 1) + 1) + 1;
    localparam int BUILD_AW = IDX_W + ((SIZE_W > ROOT_BITS) ? SIZE_W : ROOT_BITS) + 1;

    typedef enum logic [1:0] {
        CMD_LOAD_LEN = 2'd0,
        CMD_LOAD_SYM = 2'd1,
        CMD_BUILD    = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_BUILD = 1'b1;

    typedef struct packed {
        cmd_t               cmd;
        logic [LEN_W-1:0]   code_length;
        logic [CNT_W-1:0]   length_count;
        logic [SYM_W-1:0]   symbol_slot;
        logic [SYM_W-1:0]   symbol_code;
        logic [RADDR_W-1:0] read_address;
    } req_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [LEN_W-1:0]   entry_bits;
        logic [VAL_W-1:0]   entry_value;
        logic               build_status;
    } res_item_t;

    typedef struct packed {
        logic              en;
        logic [TAB_AW-1:0] addr;
        logic [LEN_W-1:0]  bits;
        logic [VAL_W-1:0]  value;
    } tbl_wr_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              ovf;
        logic [LEN_W-1:0]  hist_idx;
        logic              sym_re;
        logic [SYM_AW-1:0] sym_addr;
    } bld_ctl_t;

endpackage

`default_nettype wire

// File: rtl/htlb_build.sv
// Build sequencer that walks the length histogram and emits lookup table writes.
`default_nettype none

module htlb_build (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       ack,
    input  logic [htlb_pkg::CNT_W-1:0] hist_data,
    input  logic [htlb_pkg::SYM_W-1:0] sym_data,
    output htlb_pkg::bld_ctl_t         ctl,
    output htlb_pkg::tbl_wr_t          twr
);
    import htlb_pkg::*;

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_SUM   = 9'b000000010,
        B_SCAN  = 9'b000000100,
        B_CODE  = 9'b000001000,
        B_SUBW  = 9'b000010000,
        B_LINK  = 9'b000100000,
        B_FETCH = 9'b001000000,
        B_FILL  = 9'b010000000,
        B_DONE  = 9'b100000000
    } bstate_t;

    localparam logic [BUILD_AW-1:0] ROOT_SIZE = BUILD_AW'(1) << ROOT_BITS;
    localparam logic [LEN_W-1:0]    ROOT_LEN  = LEN_W'(ROOT_BITS);
    localparam logic [LEN_W-1:0]    MAX_LEN   = LEN_W'(MAX_CODE_LENGTH);

    bstate_t                   state_reg, state_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          total_reg, total_next;
    logic [BUILD_AW-1:0]       key_reg, key_next;
    logic [BUILD_AW-1:0]       base_reg, base_next;
    logic [SIZE_W-1:0]         size_reg, size_next;
    logic [LOW_W-1:0]          low_reg, low_next;
    logic [TB_W-1:0]           tbits_reg, tbits_next;
    logic [REPS_W-1:0]         reps_reg, reps_next;
    logic [LEN_W-1:0]          ebits_reg, ebits_next;
    logic                      single_reg, single_next;
    logic                      symok_reg, symok_next;
    logic                      ovf_reg, ovf_next;
    logic [LEN_W-1:0]          sw_len_reg, sw_len_next;
    logic signed [LEFT_W-1:0]  sw_left_reg, sw_left_next;

    logic [LEN_W-1:0]          cbits;
    logic [REPS_W-1:0]         sub_reps;
    logic [CNT_W-1:0]          sw_cur;
    logic signed [LEFT_W-1:0]  sw_diff;
    logic                      sw_stop;
    logic [BUILD_AW-1:0]       fill_addr;
    logic [SYM_W-1:0]          fill_sym;
    logic [BUILD_AW-1:0]       link_offset;
    logic                      wr_req;
    logic [BUILD_AW-1:0]       wr_addr;
    logic [LEN_W-1:0]          wr_bits;
    logic [VAL_W-1:0]          wr_value;
    logic                      wr_in_range;

    assign cbits    = len_reg - ROOT_LEN;
    assign sub_reps = (cbits <= LEN_W'(tbits_reg))
                    ? (REPS_W'(1) << (LEN_W'(tbits_reg) - cbits)) : REPS_W'(1);
    assign sw_cur   = (sw_len_reg == len_reg) ? rem_reg : hist_data;
    assign sw_diff  = sw_left_reg - $signed({{(LEFT_W - CNT_W){1'b0}}, sw_cur});
    assign sw_stop  = sw_diff[LEFT_W-1] || (sw_diff == '0);
    assign fill_addr = (!single_reg && (len_reg > ROOT_LEN))
                     ? base_reg + BUILD_AW'(low_reg) : key_reg;
    assign fill_sym    = symok_reg ? sym_data : '0;
    assign link_offset = base_reg - key_reg;
    assign wr_in_range = wr_addr < BUILD_AW'(TABLE_DEPTH);

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        key_next     = key_reg;
        base_next    = base_reg;
        size_next    = size_reg;
        low_next     = low_reg;
        tbits_next   = tbits_reg;
        reps_next    = reps_reg;
        ebits_next   = ebits_reg;
        single_next  = single_reg;
        symok_next   = symok_reg;
        sw_len_next  = sw_len_reg;
        sw_left_next = sw_left_reg;
        wr_req       = 1'b0;
        wr_addr      = fill_addr;
        wr_bits      = ebits_reg;
        wr_value     = VAL_W'(fill_sym);

        ctl.busy     = (state_reg != B_IDLE);
        ctl.done     = (state_reg == B_DONE);
        ctl.ovf      = ovf_reg;
        ctl.hist_idx = (state_reg == B_SUBW) ? sw_len_reg : len_reg;
        ctl.sym_re   = 1'b0;
        ctl.sym_addr = idx_reg[SYM_AW-1:0];

        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    len_next    = LEN_W'(1);
                    total_next  = '0;
                    idx_next    = '0;
                    key_next    = '0;
                    base_next   = ROOT_SIZE;
                    size_next   = '0;
                    low_next    = '0;
                    tbits_next  = '0;
                    single_next = 1'b0;
                    state_next  = B_SUM;
                end
            end
            B_SUM:
            begin
                total_next = total_reg + IDX_W'(hist_data);
                if (len_reg == MAX_LEN)
                begin
                    if (total_next == IDX_W'(1))
                    begin
                        single_next = 1'b1;
                        reps_next   = REPS_W'(1) << ROOT_BITS;
                        ebits_next  = '0;
                        state_next  = B_FETCH;
                    end
                    else
                    begin
                        len_next   = LEN_W'(1);
                        state_next = B_SCAN;
                    end
                end
                else
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            B_SCAN:
            begin
                if (len_reg > MAX_LEN)
                begin
                    state_next = B_DONE;
                end
                else if (hist_data == '0)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    rem_next   = hist_data;
                    state_next = B_CODE;
                end
            end
            B_CODE:
            begin
                if (len_reg <= ROOT_LEN)
                begin
                    reps_next  = REPS_W'(1) << (ROOT_LEN - len_reg);
                    ebits_next = len_reg;
                    state_next = B_FETCH;
                end
                else
                begin
                    ebits_next = cbits;
                    if (LOW_W'(size_reg) <= low_reg)
                    begin
                        base_next    = base_reg + BUILD_AW'(size_reg);
                        sw_len_next  = len_reg;
                        sw_left_next = LEFT_W'(1) << cbits;
                        state_next   = B_SUBW;
                    end
                    else
                    begin
                        reps_next  = sub_reps;
                        state_next = B_FETCH;
                    end
                end
            end
            B_SUBW:
            begin
                if (sw_len_reg >= MAX_LEN || sw_stop)
                begin
                    tbits_next = TB_W'(sw_len_reg - ROOT_LEN);
                    state_next = B_LINK;
                end
                else
                begin
                    sw_len_next  = sw_len_reg + LEN_W'(1);
                    sw_left_next = sw_diff <<< 1;
                end
            end
            B_LINK:
            begin
                size_next  = SIZE_W'(1) << tbits_reg;
                low_next   = '0;
                wr_req     = 1'b1;
                wr_addr    = key_reg;
                wr_bits    = LEN_W'(tbits_reg) + ROOT_LEN;
                wr_value   = link_offset[VAL_W-1:0];
                key_next   = key_reg + BUILD_AW'(1);
                reps_next  = sub_reps;
                state_next = B_FETCH;
            end
            B_FETCH:
            begin
                ctl.sym_re = 1'b1;
                symok_next = idx_reg < IDX_W'(SYMBOL_DEPTH);
                idx_next   = idx_reg + IDX_W'(1);
                state_next = B_FILL;
            end
            B_FILL:
            begin
                wr_req    = 1'b1;
                reps_next = reps_reg - REPS_W'(1);
                if (!single_reg && (len_reg > ROOT_LEN))
                begin
                    low_next = low_reg + LOW_W'(1);
                end
                else
                begin
                    key_next = key_reg + BUILD_AW'(1);
                end
                if (reps_reg == REPS_W'(1))
                begin
                    if (single_reg)
                    begin
                        state_next = B_DONE;
                    end
                    else if (rem_reg == CNT_W'(1))
                    begin
                        len_next   = len_reg + LEN_W'(1);
                        state_next = B_SCAN;
                    end
                    else
                    begin
                        rem_next   = rem_reg - CNT_W'(1);
                        state_next = B_CODE;
                    end
                end
            end
            B_DONE:
            begin
                if (ack)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        twr.en    = wr_req && wr_in_range;
        twr.addr  = wr_addr[TAB_AW-1:0];
        twr.bits  = wr_bits;
        twr.value = wr_value;

        if (state_reg == B_IDLE && start)
        begin
            ovf_next = 1'b0;
        end
        else
        begin
            ovf_next = ovf_reg || (wr_req && !wr_in_range);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ovf_reg    <= 1'b0;
            single_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovf_reg    <= ovf_next;
            single_reg <= single_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        key_reg     <= key_next;
        base_reg    <= base_next;
        size_reg    <= size_next;
        low_reg     <= low_next;
        tbits_reg   <= tbits_next;
        reps_reg    <= reps_next;
        ebits_reg   <= ebits_next;
        symok_reg   <= symok_next;
        sw_len_reg  <= sw_len_next;
        sw_left_reg <= sw_left_next;
    end

endmodule

`default_nettype wire

// File: rtl/huffman_two_level_table_builder.sv
// Top level of the two-level Huffman decode table builder.
// A read result is registered, then offered once the output register is free.
// Loads go back to back when idle; a pending read holds input while a result is still offered.
// A build sums the histogram, then scans the lengths; for each code it links any new subtable,
// then fetches the symbol and writes each table entry; the status result comes last.
// After reset all 1024 lookup table entries are cleared, during which no item is taken.
`default_nettype none
`include "huffman_two_level_table_builder_assert.svh"

module huffman_two_level_table_builder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  htlb_pkg::req_item_t   req_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output htlb_pkg::res_item_t   res_item
);
    import htlb_pkg::*;

    logic [CNT_W-1:0]  hist_reg [0:MAX_CODE_LENGTH];
    logic [SYM_W-1:0]  sym_mem  [0:SYMBOL_DEPTH-1];
    logic [TBL_W-1:0]  tbl_mem  [0:TABLE_DEPTH-1];

    logic [SYM_W-1:0]  sym_rdata_reg;
    logic [TBL_W-1:0]  tbl_rdata_reg;
    logic              rd_zero_reg;
    logic              rd_pend_reg, rd_pend_next;
    logic              clr_busy_reg, clr_busy_next;
    logic [TAB_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              res_valid_reg, res_valid_next;
    res_item_t         res_item_reg, res_item_next;

    logic              accept;
    logic              acc_len;
    logic              acc_sym;
    logic              acc_build;
    logic              acc_read;
    logic              out_free;
    logic              bld_ack;
    logic [CNT_W-1:0]  hist_data;
    bld_ctl_t          bld_ctl;
    tbl_wr_t           bld_wr;
    tbl_wr_t           tbl_wr;

    assign req_stall = clr_busy_reg || bld_ctl.busy || (rd_pend_reg && res_valid_reg);
    assign accept    = req_valid && !req_stall;
    assign acc_len   = accept && (req_item.cmd == CMD_LOAD_LEN);
    assign acc_sym   = accept && (req_item.cmd == CMD_LOAD_SYM);
    assign acc_build = accept && (req_item.cmd == CMD_BUILD);
    assign acc_read  = accept && (req_item.cmd == CMD_READ);
    assign out_free  = !res_valid_reg || !res_stall;
    assign bld_ack   = bld_ctl.done && out_free && !rd_pend_reg;

    assign hist_data = (bld_ctl.hist_idx <= LEN_W'(MAX_CODE_LENGTH))
                     ? hist_reg[bld_ctl.hist_idx] : '0;

    htlb_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (acc_build),
        .ack       (bld_ack),
        .hist_data (hist_data),
        .sym_data  (sym_rdata_reg),
        .ctl       (bld_ctl),
        .twr       (bld_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= MAX_CODE_LENGTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (acc_len && (req_item.code_length >= LEN_W'(1))
                 && (req_item.code_length <= LEN_W'(MAX_CODE_LENGTH)))
        begin
            hist_reg[req_item.code_length] <= req_item.length_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_sym && (32'(req_item.symbol_slot) < SYMBOL_DEPTH))
        begin
            sym_mem[req_item.symbol_slot[SYM_AW-1:0]] <= req_item.symbol_code;
        end
        if (bld_ctl.sym_re)
        begin
            sym_rdata_reg <= sym_mem[bld_ctl.sym_addr];
        end
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            tbl_wr.en    = 1'b1;
            tbl_wr.addr  = clr_cnt_reg;
            tbl_wr.bits  = '0;
            tbl_wr.value = '0;
            clr_cnt_next = clr_cnt_reg + TAB_AW'(1);
            if (clr_cnt_reg == TAB_AW'(TABLE_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
        else
        begin
            tbl_wr = bld_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            tbl_mem[tbl_wr.addr] <= {tbl_wr.bits, tbl_wr.value};
        end
        if (acc_read)
        begin
            tbl_rdata_reg <= tbl_mem[TAB_AW'(req_item.read_address)];
            rd_zero_reg   <= !(32'(req_item.read_address) < TABLE_DEPTH);
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        rd_pend_next   = rd_pend_reg;
        if (rd_pend_reg && out_free)
        begin
            res_valid_next            = 1'b1;
            res_item_next.result_kind = KIND_READ;
            res_item_next.entry_bits  = rd_zero_reg ? '0 : tbl_rdata_reg[TBL_W-1:VAL_W];
            res_item_next.entry_value = rd_zero_reg ? '0 : tbl_rdata_reg[VAL_W-1:0];
            res_item_next.build_status = 1'b0;
            rd_pend_next              = 1'b0;
        end
        else if (bld_ack)
        begin
            res_valid_next             = 1'b1;
            res_item_next.result_kind  = KIND_BUILD;
            res_item_next.entry_bits   = '0;
            res_item_next.entry_value  = '0;
            res_item_next.build_status = bld_ctl.ovf;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (acc_read)
        begin
            rd_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `HTLB_ASSERT_SAME(a_clear_excludes_build, clr_busy_reg, !bld_ctl.busy)
    `HTLB_ASSERT_NEXT(a_build_starts, acc_build, bld_ctl.busy)
    `HTLB_ASSERT_SAME(a_write_in_range, tbl_wr.en, 32'(tbl_wr.addr) < TABLE_DEPTH)

endmodule

`default_nettype wire
